### hdl/hapc_pkg.sv
// hapc_pkg: shared types, constants and the arctangent table of the heading align controller
// used by hapc_ctrl, hapc_datapath and heading_align_p_controller_core; no dependencies
`timescale 1ns / 1ps

package hapc_pkg;

    localparam int DEF_STOP_BURST   = 10;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_ANGLE_BITS   = 16;

    localparam int MAX_STEPS  = 24;
    localparam int STEP_IDX_W = 5;
    localparam int CORDIC_W   = 36;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [15:0] YAW_OFFSET   = 16'h4000;

    localparam logic signed [31:0] GOAL_X_RST = 32'sd0;
    localparam logic signed [31:0] GOAL_Y_RST = 32'sd0;
    localparam logic [15:0]        GAIN_RST   = 16'd13107;
    localparam logic [14:0]        THR_RST    = 15'd1043;

    localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] RATE_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        REG_GOAL_X    = 2'd0,
        REG_GOAL_Y    = 2'd1,
        REG_GAIN      = 2'd2,
        REG_ALIGN_THR = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_ITER,
        S_ANG,
        S_MUL,
        S_OUT,
        S_BURST,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_STOP,
        KIND_DONE
    } t_kind;

    typedef struct packed {
        logic                  load;
        logic                  pre;
        logic                  step;
        logic [STEP_IDX_W-1:0] step_idx;
        logic                  ang;
        logic                  mul;
        logic                  emit;
        t_kind                 kind;
        logic                  res_last;
        logic                  res_done;
    } t_cmd;

    typedef struct packed {
        logic aligned;
        logic zero_yaw;
        logic out_free;
    } t_status;

    // atan(2^-i) as a fraction of a full turn, 2^32 units per turn
    function automatic logic [31:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/heading_align_p_controller_core.sv
// heading_align_p_controller_core: top level of the heading align proportional controller
// instantiates hapc_ctrl and hapc_datapath, depends on hapc_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready): one control tick per transfer, carrying
//   robot position (signed Q16.16) and the raw imu yaw (binary angle, 32768 = pi)
//   output channel (o_out_valid / i_out_ready): one result per transfer; o_last marks
//   the final result of a tick
//   config port: write enable, register index (0 goal_x, 1 goal_y, 2 gain,
//   3 align_threshold) and 32-bit data, taken on any clock edge with the enable high
//   results: a stop burst adds STOP_BURST more results after the first one, one per
//   cycle while the receiver takes them; once done, a tick gives a single done result
//   ticks: one at a time, set by the single iterative cordic unit; no new tick is
//   taken until the last result of the one before has been loaded
//   reset: config goes to defaults, done flag clears, no result pending
//   receiver stall: the result register holds; the sequencer waits before the next one
`timescale 1ns / 1ps

module heading_align_p_controller_core #(
    parameter int STOP_BURST   = hapc_pkg::DEF_STOP_BURST,
    parameter int CORDIC_STEPS = hapc_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_BITS   = hapc_pkg::DEF_ANGLE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    input  logic signed [15:0] i_imu_heading,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_rate_command,
    output logic signed [15:0] o_heading_error,
    output logic               o_is_stop,
    output logic               o_done_res,
    output logic               o_last
);
    import hapc_pkg::*;

    t_cmd    cmd;
    t_status status;

    hapc_ctrl #(
        .STOP_BURST   (STOP_BURST),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hapc_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_robot_x       (i_robot_x),
        .i_robot_y       (i_robot_y),
        .i_imu_heading   (i_imu_heading),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rate_command  (o_rate_command),
        .o_heading_error (o_heading_error),
        .o_is_stop       (o_is_stop),
        .o_done_res      (o_done_res),
        .o_last          (o_last)
    );

endmodule

### hdl/hapc_datapath.sv
// hapc_datapath: config registers, iterative cordic atan2, heading error, gain multiply
// and the result register; driven by hapc_ctrl commands, depends on hapc_pkg
`timescale 1ns / 1ps

module hapc_datapath #(
    parameter int ANGLE_BITS = hapc_pkg::DEF_ANGLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    input  logic signed [31:0]  i_robot_x,
    input  logic signed [31:0]  i_robot_y,
    input  logic signed [15:0]  i_imu_heading,
    input  hapc_pkg::t_cmd      i_cmd,
    output hapc_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_rate_command,
    output logic signed [15:0]  o_heading_error,
    output logic                o_is_stop,
    output logic                o_done_res,
    output logic                o_last
);
    import hapc_pkg::*;

    localparam int          DROP     = 32 - ANGLE_BITS;
    localparam logic [31:0] RND_HALF = 32'd1 << (DROP - 1);
    localparam logic [31:0] RND_MASK = ~((32'd1 << DROP) - 32'd1);

    logic signed [31:0] r_goal_x, r_goal_y;
    logic [15:0]        r_gain;
    logic [14:0]        r_thr;

    logic signed [32:0]         r_dx, r_dy;
    logic [15:0]                r_yaw_ref;
    logic                       r_zero_yaw;
    logic signed [CORDIC_W-1:0] r_x, r_y, n_x, n_y;
    logic [31:0]                r_ang, n_ang;
    logic                       r_zero_off;
    logic signed [15:0]         r_err;
    logic signed [32:0]         r_prod;
    logic                       r_aligned;

    logic                r_out_valid;
    logic signed [15:0]  r_rate, r_herr, n_rate, n_herr;
    logic                r_stop, r_done, r_last;

    logic signed [CORDIC_W-1:0] ext_dx, ext_dy, sh_x, sh_y;
    logic [31:0]                bearing, err32;
    logic signed [16:0]         err17, mag;
    logic signed [32:0]         prod_rnd;
    logic signed [16:0]         rate_wide;
    logic signed [15:0]         rate_sat;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= GOAL_X_RST;
            r_goal_y <= GOAL_Y_RST;
            r_gain   <= GAIN_RST;
            r_thr    <= THR_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_GOAL_X:    r_goal_x <= i_cfg_wdata;
                REG_GOAL_Y:    r_goal_y <= i_cfg_wdata;
                REG_GAIN:      r_gain   <= i_cfg_wdata[15:0];
                REG_ALIGN_THR: r_thr    <= i_cfg_wdata[14:0];
                default:       r_gain   <= r_gain;
            endcase
        end
    end

    // quadrant pre-rotation and one vectoring step
    always_comb begin
        ext_dx = CORDIC_W'(r_dx);
        ext_dy = CORDIC_W'(r_dy);
        sh_x   = r_x >>> i_cmd.step_idx;
        sh_y   = r_y >>> i_cmd.step_idx;
        n_x    = r_x;
        n_y    = r_y;
        n_ang  = r_ang;
        if (i_cmd.pre) begin
            if (r_dx < 0) begin
                if (r_dy >= 0) begin
                    n_x   = ext_dy;
                    n_y   = -ext_dx;
                    n_ang = QUARTER_TURN;
                end else begin
                    n_x   = -ext_dy;
                    n_y   = ext_dx;
                    n_ang = 32'd0 - QUARTER_TURN;
                end
            end else begin
                n_x   = ext_dx;
                n_y   = ext_dy;
                n_ang = 32'd0;
            end
        end else if (i_cmd.step) begin
            if (r_y > 0) begin
                n_x   = r_x + sh_y;
                n_y   = r_y - sh_x;
                n_ang = r_ang + atan_turn(i_cmd.step_idx);
            end else begin
                n_x   = r_x - sh_y;
                n_y   = r_y + sh_x;
                n_ang = r_ang - atan_turn(i_cmd.step_idx);
            end
        end
    end

    assign bearing = r_zero_off ? 32'd0 : ((r_ang + RND_HALF) & RND_MASK);
    assign err32   = bearing - {r_yaw_ref, 16'h0000};
    assign err17   = 17'(r_err);
    assign mag     = (err17 < 0) ? -err17 : err17;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx       <= 33'(r_goal_x) - 33'(i_robot_x);
            r_dy       <= 33'(r_goal_y) - 33'(i_robot_y);
            r_yaw_ref  <= i_imu_heading + YAW_OFFSET;
            r_zero_yaw <= (i_imu_heading == 16'sd0);
        end
        if (i_cmd.pre) begin
            r_zero_off <= (r_dx == 33'sd0) && (r_dy == 33'sd0);
        end
        if (i_cmd.pre || i_cmd.step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
        end
        if (i_cmd.ang) begin
            r_err <= err32[31:16];
        end
        if (i_cmd.mul) begin
            r_prod    <= 33'(signed'({1'b0, r_gain})) * 33'(r_err);
            r_aligned <= $unsigned(mag) < {2'b00, r_thr};
        end
    end

    // round half up, then saturate
    always_comb begin
        prod_rnd  = r_prod + 33'sd32768;
        rate_wide = 17'(prod_rnd >>> 16);
        if (rate_wide > 17'(RATE_MAX)) begin
            rate_sat = RATE_MAX;
        end else if (rate_wide < 17'(RATE_MIN)) begin
            rate_sat = RATE_MIN;
        end else begin
            rate_sat = rate_wide[15:0];
        end
    end

    always_comb begin
        case (i_cmd.kind)
            KIND_FIRST: begin
                n_rate = rate_sat;
                n_herr = r_err;
            end
            KIND_STOP: begin
                n_rate = 16'sd0;
                n_herr = r_err;
            end
            default: begin
                n_rate = 16'sd0;
                n_herr = 16'sd0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rate <= n_rate;
            r_herr <= n_herr;
            r_stop <= (i_cmd.kind == KIND_STOP);
            r_done <= i_cmd.res_done;
            r_last <= i_cmd.res_last;
        end
    end

    assign o_status.aligned  = r_aligned;
    assign o_status.zero_yaw = r_zero_yaw;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_rate_command  = r_rate;
    assign o_heading_error = r_herr;
    assign o_is_stop       = r_stop;
    assign o_done_res      = r_done;
    assign o_last          = r_last;

endmodule

### hdl/hapc_ctrl.sv
// hapc_ctrl: sequencer for the heading align controller; counts cordic steps and stop
// bursts and holds the done flag; depends on hapc_pkg
`timescale 1ns / 1ps

module hapc_ctrl #(
    parameter int STOP_BURST   = hapc_pkg::DEF_STOP_BURST,
    parameter int CORDIC_STEPS = hapc_pkg::DEF_CORDIC_STEPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hapc_pkg::t_status i_status,
    output hapc_pkg::t_cmd    o_cmd
);
    import hapc_pkg::*;

    localparam int SCW = $clog2(CORDIC_STEPS);
    localparam int BCW = $clog2(STOP_BURST + 1);
    localparam logic [SCW-1:0] STEP_LAST  = SCW'(CORDIC_STEPS - 1);
    localparam logic [BCW-1:0] BURST_LAST = BCW'(STOP_BURST - 1);

    t_state         r_state, n_state;
    logic [SCW-1:0] r_step, n_step;
    logic [BCW-1:0] r_burst, n_burst;
    logic           r_finished, n_finished;
    logic           burst_end, need_burst;

    assign burst_end  = (r_burst == BURST_LAST);
    assign need_burst = i_status.aligned || i_status.zero_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_burst    <= '0;
            r_finished <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_burst    <= n_burst;
            r_finished <= n_finished;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_burst    = r_burst;
        n_finished = r_finished;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_finished ? S_FIN : S_PRE;
                end
            end
            S_PRE: begin
                n_step  = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_ANG;
                end
            end
            S_ANG: n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: begin
                n_burst = '0;
                if (i_status.out_free) begin
                    n_state = need_burst ? S_BURST : S_IDLE;
                end
            end
            S_BURST: begin
                if (i_status.out_free) begin
                    n_burst = r_burst + 1'b1;
                    if (burst_end) begin
                        n_state = S_IDLE;
                        if (i_status.aligned) begin
                            n_finished = 1'b1;
                        end
                    end
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.kind      = KIND_FIRST;
        o_cmd.step_idx  = STEP_IDX_W'(r_step);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PRE:  o_cmd.pre  = 1'b1;
            S_ITER: o_cmd.step = 1'b1;
            S_ANG:  o_cmd.ang  = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_OUT: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.kind     = KIND_FIRST;
                o_cmd.res_last = !need_burst;
            end
            S_BURST: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.kind     = KIND_STOP;
                o_cmd.res_last = burst_end;
                o_cmd.res_done = burst_end && i_status.aligned;
            end
            S_FIN: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.kind     = KIND_DONE;
                o_cmd.res_last = 1'b1;
                o_cmd.res_done = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

### dv/hapc_cmd_scoreboard.sv
// hapc_cmd_scoreboard: bearing and rate command predictor plus the store of expected results
// for the heading align controller testbench; depends on hapc_pkg
`timescale 1ns / 1ps

package hapc_sb_pkg;

    import hapc_pkg::*;

    localparam int TURN_STEPS = 16;
    localparam int BURST_LEN  = 10;
    localparam int ANGLE_RES  = 16;

    // atan(2^-i) in turn fractions, 2^32 per turn
    localparam logic [31:0] ATAN_STEP [TURN_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic signed [15:0] rate;
        logic signed [15:0] err;
        logic               stop;
        logic               done;
        logic               last;
    } rate_result_t;

    class rate_cmd_scoreboard;

        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        gain;
        logic [14:0]        align_thr;
        bit                 finished;
        rate_result_t       expected_cmds[$];
        int                 fails;

        function new();
            goal_x    = GOAL_X_RST;
            goal_y    = GOAL_Y_RST;
            gain      = GAIN_RST;
            align_thr = THR_RST;
            finished  = 1'b0;
            fails     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                REG_GOAL_X:    goal_x = value;
                REG_GOAL_Y:    goal_y = value;
                REG_GAIN:      gain = value[15:0];
                REG_ALIGN_THR: align_thr = value[14:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function logic [31:0] bearing_turns(longint dx, longint dy);
            longint      x;
            longint      y;
            longint      t;
            logic [31:0] ang;
            if (dx == 0 && dy == 0)
                return 32'd0;
            x   = dx;
            y   = dy;
            ang = 32'd0;
            // fold the left half plane onto the right one
            if (dx < 0) begin
                if (dy >= 0) begin
                    x   = dy;
                    y   = -dx;
                    ang = QUARTER_TURN;
                end else begin
                    x   = -dy;
                    y   = dx;
                    ang = 32'd0 - QUARTER_TURN;
                end
            end
            for (int i = 0; i < TURN_STEPS; i++) begin
                if (y > 0) begin
                    t   = x + (y >>> i);
                    y   = y - (x >>> i);
                    ang = ang + ATAN_STEP[i];
                end else begin
                    t   = x - (y >>> i);
                    y   = y + (x >>> i);
                    ang = ang - ATAN_STEP[i];
                end
                x = t;
            end
            ang = (ang + (32'd1 << (31 - ANGLE_RES))) & ~((32'd1 << (32 - ANGLE_RES)) - 32'd1);
            return ang;
        endfunction

        function void push_cmd(logic signed [15:0] rate_v, logic signed [15:0] err_v,
                               logic stop_v, logic done_v, logic last_v);
            rate_result_t r;
            r.rate = rate_v;
            r.err  = err_v;
            r.stop = stop_v;
            r.done = done_v;
            r.last = last_v;
            expected_cmds.push_back(r);
        endfunction

        function void note_tick(logic signed [31:0] rx, logic signed [31:0] ry,
                                logic signed [15:0] yaw);
            logic [31:0]        err_turns;
            logic signed [15:0] err;
            longint             prod;
            longint             rate;
            longint             mag;
            bit                 zero_yaw;
            bit                 aligned;
            if (finished) begin
                push_cmd(16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1);
                return;
            end
            err_turns = bearing_turns(longint'(goal_x) - longint'(rx),
                                      longint'(goal_y) - longint'(ry))
                      - ({yaw, 16'h0000} + QUARTER_TURN);
            err  = err_turns[31:16];
            prod = longint'(gain) * longint'(err);
            rate = (prod + 64'sd32768) >>> 16;
            if (rate > 32767)
                rate = 32767;
            else if (rate < -32768)
                rate = -32768;
            mag      = (err < 0) ? -longint'(err) : longint'(err);
            zero_yaw = (yaw == 16'sd0);
            aligned  = (mag < longint'(align_thr));
            push_cmd(rate[15:0], err, 1'b0, 1'b0, !(aligned || zero_yaw));
            if (aligned || zero_yaw) begin
                for (int k = 0; k < BURST_LEN; k++)
                    push_cmd(16'sd0, err, 1'b1, aligned && (k == BURST_LEN - 1),
                             k == BURST_LEN - 1);
            end
            if (aligned)
                finished = 1'b1;
        endfunction

        function void check_command(rate_result_t got);
            rate_result_t want;
            if (expected_cmds.size() == 0) begin
                $error("unexpected result: rate_command %0d heading_error %0d",
                       got.rate, got.err);
                fails++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got.rate !== want.rate) begin
                $error("rate_command expected %0d actual %0d", want.rate, got.rate);
                fails++;
            end
            if (got.err !== want.err) begin
                $error("heading_error expected %0d actual %0d", want.err, got.err);
                fails++;
            end
            if (got.stop !== want.stop) begin
                $error("is_stop expected %0b actual %0b", want.stop, got.stop);
                fails++;
            end
            if (got.done !== want.done) begin
                $error("done_res expected %0b actual %0b", want.done, got.done);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0b actual %0b", want.last, got.last);
                fails++;
            end
        endfunction

    endclass

endpackage

### dv/heading_align_p_controller_core_tb.sv
// heading_align_p_controller_core_tb: drives control ticks and register writes into the
// heading align controller and checks every result transfer against the scoreboard
// depends on hapc_pkg, hapc_sb_pkg and heading_align_p_controller_core
`timescale 1ns / 1ps

module heading_align_p_controller_core_tb;

    import hapc_pkg::*;
    import hapc_sb_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_TICKS   = 115;
    localparam int HOLD_STRETCH  = 300;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_wr_en     = 1'b0;
    logic [1:0]         i_cfg_idx       = '0;
    logic [31:0]        i_cfg_wdata     = '0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_robot_x       = '0;
    logic signed [31:0] i_robot_y       = '0;
    logic signed [15:0] i_imu_heading   = '0;
    logic               o_out_valid;
    logic               i_out_ready     = 1'b0;
    logic signed [15:0] o_rate_command;
    logic signed [15:0] o_heading_error;
    logic               o_is_stop;
    logic               o_done_res;
    logic               o_last;

    rate_cmd_scoreboard sb;
    rate_result_t       seen;
    bit                 calm        = 1'b0;
    bit                 hold_req    = 1'b0;
    bit                 hold_taken  = 1'b0;
    int                 hold_left   = 0;
    int                 cycle_count = 0;

    heading_align_p_controller_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_robot_x       (i_robot_x),
        .i_robot_y       (i_robot_y),
        .i_imu_heading   (i_imu_heading),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rate_command  (o_rate_command),
        .o_heading_error (o_heading_error),
        .o_is_stop       (o_is_stop),
        .o_done_res      (o_done_res),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.rate = o_rate_command;
            seen.err  = o_heading_error;
            seen.stop = o_is_stop;
            seen.done = o_done_res;
            seen.last = o_last;
            sb.check_command(seen);
        end
        if (hold_req && !hold_taken) begin
            hold_left  = HOLD_STRETCH;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic program_regs(input logic [31:0] gx, input logic [31:0] gy,
                                input logic [31:0] gain_word, input logic [31:0] thr_word);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GAIN, gain_word);
        write_reg(REG_ALIGN_THR, thr_word);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(input logic signed [31:0] rx, input logic signed [31:0] ry,
                             input logic signed [15:0] yaw);
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_robot_x     <= rx;
        i_robot_y     <= ry;
        i_imu_heading <= yaw;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_tick(rx, ry, yaw);
    endtask

    task automatic send_random_tick();
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [15:0] yaw;
        int                 pick;
        int                 ypick;
        pick  = $urandom_range(0, 9);
        ypick = $urandom_range(0, 19);
        rx    = $urandom();
        ry    = $urandom();
        yaw   = 16'($urandom());
        case (pick)
            0: begin
                rx = sb.goal_x;
                ry = sb.goal_y;
            end
            1, 2: begin
                rx = sb.goal_x + 32'($urandom_range(0, 64)) - 32'sd32;
                ry = sb.goal_y + 32'($urandom_range(0, 64)) - 32'sd32;
            end
            3: begin
                rx = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                ry = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            default: ;
        endcase
        case (ypick)
            0, 1:    yaw = 16'sd0;
            2:       yaw = 16'sh8000;
            3:       yaw = 16'sh7FFF;
            default: ;
        endcase
        send_tick(rx, ry, yaw);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // goal at origin, full gain, alignment disabled
        program_regs(32'h0, 32'h0, {16'($urandom()), 16'hFFFF}, {17'($urandom()), 15'd0});
        send_tick(32'sd0, 32'sd0, 16'sh1234);
        send_tick(32'sd0, 32'sd0, 16'sd0);
        send_tick(32'sh8000_0000, 32'sd0, 16'sh4000);
        send_tick(32'sh8000_0000, 32'sh8000_0000, 16'sh4001);
        send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh8000);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'shC000);
        send_tick(-32'sd1, 32'sd0, 16'sh0001);
        send_tick(32'sd0, -32'sd1, 16'shFFFF);
        send_tick(32'sd1, 32'sd0, 16'sd0);
        send_tick(32'sd0, 32'sd1, 16'sh2000);
        send_tick(32'sh0001_0000, 32'shFFFF_0000, 16'shE000);

        // goal at the corner, zero gain
        drain_results();
        program_regs(32'h7FFF_FFFF, 32'h8000_0000, {16'($urandom()), 16'h0000},
                     {17'($urandom()), 15'd0});
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh0100);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0);
        send_tick(32'sd0, 32'sd0, 16'sh7FFF);

        for (int p = 0; p < 4; p++) begin
            drain_results();
            case (p)
                1: program_regs(32'h8000_0000, 32'h7FFF_FFFF, {16'($urandom()), 16'hFFFF},
                                {17'($urandom()), 15'd0});
                2: program_regs(32'h0, 32'h0, {16'($urandom()), 16'h0001},
                                {17'($urandom()), 15'd0});
                default: program_regs($urandom(), $urandom(), $urandom(),
                                      {17'($urandom()), 15'd0});
            endcase
            calm = (p == 1);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // receiver stalls while ticks keep coming
                if (p == 0 && n == 5)
                    hold_req = 1'b1;
                send_random_tick();
            end
        end

        // widest threshold: aligned together with zero yaw, then latched done
        drain_results();
        calm = 1'b0;
        program_regs(32'h0, 32'h0, $urandom(), {17'($urandom()), 15'h7FFF});
        send_tick(32'sd0, 32'sd0, 16'sd0);
        repeat (4) send_random_tick();
        drain_results();
        repeat (40) @(posedge i_clk);

        if (sb.fails == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hdl/hapc_pkg.sv
hdl/hapc_datapath.sv
hdl/hapc_ctrl.sv
hdl/heading_align_p_controller_core.sv
dv/hapc_cmd_scoreboard.sv
dv/heading_align_p_controller_core_tb.sv
